// ===== rtl/core/nth_hamming_number_generator_core_assert.svh =====
// Assertion macros shared by the Hamming number generator core.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the user.
`ifndef NTH_HAMMING_NUMBER_GENERATOR_CORE_ASSERT_SVH
`define NTH_HAMMING_NUMBER_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication
`define HNG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// next-cycle implication
`define HNG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// ===== rtl/core/hng_pkg.sv =====
// Shared widths and controller/datapath interface structs for the Hamming core.
// No dependencies.
package hng_pkg;

    localparam int IDX_W  = 11;   // request index width
    localparam int VAL_W  = 31;   // stored / returned value width
    localparam int PROD_W = 34;   // widest candidate product (value * 5)

    typedef struct packed {
        logic accept;    // latch request index
        logic init;      // seed entry 0 with 1
        logic rd23;      // read entries at pointer_two / pointer_three
        logic rd5;       // read entry at pointer_five, form x2 / x3 products
        logic prod5;     // form x5 product
        logic merge;     // write minimum, advance pointers
        logic rd_out;    // read requested entry
        logic load_out;  // register result and strobe it
        logic load_err;  // register error result and strobe it
    } t_cmd;

    typedef struct packed {
        logic req_bad;      // incoming index is 0 or beyond depth
        logic fill_zero;    // table is empty
        logic req_pending;  // incoming index lies beyond the filled part
        logic more;         // another merge step is needed after this one
    } t_status;

endpackage

// ===== rtl/core/hng_controller.sv =====
// Controller state machine of the Hamming core: sequences seed, merge steps and readout.
// Depends on hng_pkg.
module hng_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  hng_pkg::t_status i_status,
    output hng_pkg::t_cmd    o_cmd
);
    import hng_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_INIT  = 8'b0000_0010,
        S_RD23  = 8'b0000_0100,
        S_RD5   = 8'b0000_1000,
        S_PROD5 = 8'b0001_0000,
        S_MERGE = 8'b0010_0000,
        S_RDOUT = 8'b0100_0000,
        S_LOAD  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_status.req_bad) begin
                        o_cmd.load_err = 1'b1;
                    end else begin
                        o_cmd.accept = 1'b1;
                        if (i_status.fill_zero) begin
                            n_state = S_INIT;
                        end else if (i_status.req_pending) begin
                            n_state = S_RD23;
                        end else begin
                            n_state = S_RDOUT;
                        end
                    end
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = i_status.more ? S_RD23 : S_RDOUT;
            end
            S_RD23: begin
                o_cmd.rd23 = 1'b1;
                n_state    = S_RD5;
            end
            S_RD5: begin
                o_cmd.rd5 = 1'b1;
                n_state   = S_PROD5;
            end
            S_PROD5: begin
                o_cmd.prod5 = 1'b1;
                n_state     = S_MERGE;
            end
            S_MERGE: begin
                o_cmd.merge = 1'b1;
                n_state     = i_status.more ? S_RD23 : S_RDOUT;
            end
            S_RDOUT: begin
                o_cmd.rd_out = 1'b1;
                n_state      = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load_out = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ===== rtl/core/hng_datapath.sv =====
// Datapath of the Hamming core: sequence table, merge pointers, products, result register.
// Depends on hng_pkg and nth_hamming_number_generator_core_assert.svh.
module hng_datapath #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [hng_pkg::IDX_W-1:0] i_request_index,
    input  hng_pkg::t_cmd             i_cmd,
    output hng_pkg::t_status          o_status,
    output logic [hng_pkg::VAL_W-1:0] o_hamming_value,
    output logic                      o_index_error,
    output logic                      o_done
);
    import hng_pkg::*;

    `include "nth_hamming_number_generator_core_assert.svh"

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FW = $clog2(TABLE_DEPTH + 1);

    logic [VAL_W-1:0]  r_mem [TABLE_DEPTH];
    logic [VAL_W-1:0]  r_rd_a;
    logic [VAL_W-1:0]  r_rd_b;
    logic [AW-1:0]     rd_addr_a;

    logic [AW-1:0]     r_p2;
    logic [AW-1:0]     r_p3;
    logic [AW-1:0]     r_p5;
    logic [FW-1:0]     r_fill;
    logic [IDX_W-1:0]  r_n;

    logic [PROD_W-1:0] r_c2;
    logic [PROD_W-1:0] r_c3;
    logic [PROD_W-1:0] r_c5;
    logic [PROD_W-1:0] min23;
    logic [PROD_W-1:0] min_all;

    logic [VAL_W-1:0]  r_value;
    logic              r_err;
    logic              r_strobe;

    // status toward the controller
    assign o_status.req_bad     = (i_request_index == '0) ||
                                  (i_request_index > IDX_W'(TABLE_DEPTH));
    assign o_status.fill_zero   = (r_fill == '0);
    assign o_status.req_pending = (IDX_W'(r_fill) < i_request_index);
    assign o_status.more        = ((IDX_W + 1)'(r_fill) + (IDX_W + 1)'(1)) <
                                  (IDX_W + 1)'(r_n);

    // port A address: pointer_two, pointer_five or the requested entry
    always_comb begin
        rd_addr_a = r_p2;
        if (i_cmd.rd5) begin
            rd_addr_a = r_p5;
        end else if (i_cmd.rd_out) begin
            rd_addr_a = AW'(r_n - IDX_W'(1));
        end
    end

    // table: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_mem[0] <= VAL_W'(1);
        end else if (i_cmd.merge) begin
            r_mem[r_fill[AW-1:0]] <= min_all[VAL_W-1:0];
        end
        r_rd_a <= r_mem[rd_addr_a];
        if (i_cmd.rd23) begin
            r_rd_b <= r_mem[r_p3];
        end
    end

    // candidate products: x2 by shift, x3 and x5 by one add each
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd5) begin
            r_c2 <= PROD_W'(r_rd_a) << 1;
            r_c3 <= PROD_W'(r_rd_b) + (PROD_W'(r_rd_b) << 1);
        end
        if (i_cmd.prod5) begin
            r_c5 <= PROD_W'(r_rd_a) + (PROD_W'(r_rd_a) << 2);
        end
    end

    assign min23   = (r_c3 < r_c2) ? r_c3 : r_c2;
    assign min_all = (r_c5 < min23) ? r_c5 : min23;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2   <= '0;
            r_p3   <= '0;
            r_p5   <= '0;
            r_fill <= '0;
        end else if (i_cmd.init) begin
            r_p2   <= '0;
            r_p3   <= '0;
            r_p5   <= '0;
            r_fill <= FW'(1);
        end else if (i_cmd.merge) begin
            r_fill <= r_fill + FW'(1);
            if (r_c2 == min_all) begin
                r_p2 <= r_p2 + AW'(1);
            end
            if (r_c3 == min_all) begin
                r_p3 <= r_p3 + AW'(1);
            end
            if (r_c5 == min_all) begin
                r_p5 <= r_p5 + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_n <= i_request_index;
        end
    end

    // result register, strobed for one cycle per item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_value <= r_rd_a;
            r_err   <= 1'b0;
        end else if (i_cmd.load_err) begin
            r_value <= '0;
            r_err   <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.load_out | i_cmd.load_err;
        end
    end

    assign o_hamming_value = r_value;
    assign o_index_error   = r_err;
    assign o_done          = r_strobe;

    `HNG_ASSERT_IMPL(a_fill_in_range, 1'b1, r_fill <= FW'(TABLE_DEPTH))
    `HNG_ASSERT_IMPL(a_ptr_order, r_fill != '0,
        (r_p5 <= r_p3) && (r_p3 <= r_p2) && (FW'(r_p2) < r_fill))
    `HNG_ASSERT_NEXT(a_merge_grows, i_cmd.merge, r_fill == $past(r_fill) + FW'(1))
    `HNG_ASSERT_IMPL(a_merge_nonzero, i_cmd.merge, min_all != '0)

endmodule

// ===== rtl/core/nth_hamming_number_generator_core.sv =====
// An index of 0 or beyond TABLE_DEPTH strobes its error result the cycle after start.
// A valid index runs the seed step on the first valid request after reset, then the merge
// steps it still lacks (read pointer_two/three, read pointer_five, x5 product, merge), then
// readout and load. A new item is accepted in the cycle its predecessor strobes.
// Reset: synchronous, active low; clears pointers and fill count, table contents are left
// as is and never read before written, so no clearing pass.
module nth_hamming_number_generator_core #(
    parameter int TABLE_DEPTH = 1024   // 1 .. 1690
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [hng_pkg::IDX_W-1:0] i_request_index,
    output logic [hng_pkg::VAL_W-1:0] o_hamming_value,
    output logic                      o_index_error,
    output logic                      o_done
);
    import hng_pkg::*;

    // The table persists across requests: a request only merges the entries it
    // still lacks, then reads its answer from the table.
    t_cmd    cmd;
    t_status status;

    // sequencing: idle -> (seed) -> {read 2/3, read 5, x5, merge}* -> readout -> load
    hng_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // table memory, three merge pointers, fill count, product/min logic, result register
    hng_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_request_index (i_request_index),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_hamming_value (o_hamming_value),
        .o_index_error   (o_index_error),
        .o_done          (o_done)
    );

endmodule
